### rtl/ascii_binary_stream_deframer_defines.svh
// assertion macros for the checker file
`ifndef ASCII_BINARY_STREAM_DEFRAMER_DEFINES_SVH
`define ASCII_BINARY_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ABSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ABSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/absd_pkg.sv
`timescale 1ns / 1ps

package absd_pkg;

    localparam int LINE_MAX   = 64;
    localparam int LEN_BITS   = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_RESET  = 64;
    localparam int ADDR_W     = $clog2(LINE_MAX);
    localparam int LEN_W      = $clog2(LINE_MAX + 1);
    localparam int CNT_W      = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
    localparam int SKIP_W     = 4;
    localparam int PAD_END    = 11;
    localparam int PREFIX_LEN = 7;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;

    localparam logic [2:0] MSG_LINE      = 3'd0;
    localparam logic [2:0] MSG_SAMPLE    = 3'd1;
    localparam logic [2:0] MSG_PARAMS    = 3'd2;
    localparam logic [2:0] MSG_OP_STATUS = 3'd3;
    localparam logic [2:0] MSG_SCOPE     = 3'd4;
    localparam logic [2:0] MSG_ERROR     = 3'd5;

    localparam logic CFG_OP_STATUS = 1'b0;
    localparam logic CFG_SCOPE     = 1'b1;

    // bit positions of the first-character hit vector
    localparam int HEAD_P = 0;
    localparam int HEAD_T = 1;
    localparam int HEAD_C = 2;
    localparam int HEAD_O = 3;
    localparam int HEAD_S = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] msg_type;
        logic [7:0] data_byte;
        logic       last;
        logic       truncated;
    } out_item_t;

    // one entry of the queue between front and back
    typedef struct packed {
        logic             is_flush;
        out_item_t        item;
        logic [LEN_W-1:0] count;
    } cmd_t;

    typedef enum logic {
        B_IDLE,
        B_LOAD
    } back_state_t;

    // "_BEGIN" tail of every block header, positions 1 to 6
    function automatic logic [7:0] tail_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd1:    ch = 8'h5F;
            3'd2:    ch = 8'h42;
            3'd3:    ch = 8'h45;
            3'd4:    ch = 8'h47;
            3'd5:    ch = 8'h49;
            3'd6:    ch = 8'h4E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/ascii_binary_stream_deframer.sv
// every result passes the command queue and output register, a line character also
// the store read register; throughput: one input byte per cycle while the queue has
// room, line bytes waiting until a line is read out; a line leaves the store at one
// character per cycle unless the output stalls, set by the single store read port
// reset: rst_n clears all control state at once, both block lengths return to 64;
// the line store is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module ascii_binary_stream_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [absd_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  absd_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output absd_pkg::out_item_t           out_item
);

    logic                          push;
    absd_pkg::cmd_t                push_cmd;
    logic                          pop;
    absd_pkg::cmd_t                head;
    logic                          fifo_full;
    logic                          fifo_empty;
    logic                          flush_done;
    logic                          wr_en;
    logic [absd_pkg::ADDR_W-1:0]   wr_addr;
    logic [7:0]                    wr_data;
    logic                          rd_en;
    logic [absd_pkg::ADDR_W-1:0]   rd_addr;
    logic [7:0]                    rd_data;

    absd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .fifo_full   (fifo_full),
        .flush_done  (flush_done),
        .push        (push),
        .push_cmd    (push_cmd),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    absd_ram #(
        .WIDTH (8),
        .DEPTH (absd_pkg::LINE_MAX)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    absd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    absd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .flush_done (flush_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### rtl/absd_ram.sv
`timescale 1ns / 1ps

module absd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/absd_fifo.sv
`timescale 1ns / 1ps

module absd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  absd_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output absd_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);

    absd_pkg::cmd_t                 entry_reg [absd_pkg::FIFO_DEPTH];
    logic [absd_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [absd_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [absd_pkg::PTR_W:0]       count_reg, count_next;

    assign full  = (count_reg == (absd_pkg::PTR_W + 1)'(absd_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/absd_front.sv
`timescale 1ns / 1ps

module absd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [absd_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  absd_pkg::in_item_t            in_item,
    input  logic                          fifo_full,
    input  logic                          flush_done,
    output logic                          push,
    output absd_pkg::cmd_t                push_cmd,
    output logic                          wr_en,
    output logic [absd_pkg::ADDR_W-1:0]   wr_addr,
    output logic [7:0]                    wr_data
);

    localparam int LW = absd_pkg::LEN_W;
    localparam int NB = absd_pkg::LEN_BITS;
    localparam int CW = absd_pkg::CNT_W;
    localparam int SW = absd_pkg::SKIP_W;

    logic [2:0]                 mode_reg, mode_next;
    logic [LW-1:0]              line_len_reg, line_len_next;
    logic [1:0]                 under_cnt_reg, under_cnt_next;
    logic [NB-1:0]              accum_reg, accum_next;
    logic                       digits_done_reg, digits_done_next;
    logic [SW-1:0]              skip_left_reg, skip_left_next;
    logic [CW-1:0]              bytes_left_reg, bytes_left_next;
    logic                       overflow_reg, overflow_next;
    logic [4:0]                 head_hit_reg, head_hit_next;
    logic                       tail_ok_reg, tail_ok_next;
    logic                       store_busy_reg, store_busy_next;
    logic [absd_pkg::CFG_W-1:0] op_len_reg, op_len_next;
    logic [absd_pkg::CFG_W-1:0] scope_len_reg, scope_len_next;

    logic [7:0]    ch;
    logic          take;
    logic          is_digit;
    logic [NB+3:0] accum_ext;
    logic [NB-1:0] accum_sat;
    logic          prefix_ok;
    logic [SW-1:0] pad_skip;
    logic [2:0]    blk_type;
    logic [CW-1:0] blk_len;
    logic [SW-1:0] blk_skip;
    logic          fin;

    assign ch       = in_item.byte_value;
    // line bytes wait while the store is still being read out
    assign in_ready = !fifo_full && !((mode_reg == absd_pkg::MSG_LINE) && store_busy_reg);
    assign take     = in_valid && in_ready;
    assign is_digit = (ch >= absd_pkg::CH_ZERO) && (ch <= absd_pkg::CH_NINE);

    // times ten plus digit, saturating
    assign accum_ext = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + (NB + 4)'(ch - absd_pkg::CH_ZERO);
    assign accum_sat = (accum_ext[NB+3:NB] != '0) ? '1 : accum_ext[NB-1:0];

    assign prefix_ok = (line_len_reg >= LW'(absd_pkg::PREFIX_LEN)) && tail_ok_reg;
    assign pad_skip  = (line_len_reg < LW'(absd_pkg::PAD_END))
                     ? SW'(LW'(absd_pkg::PAD_END) - line_len_reg) : '0;
    assign fin       = (bytes_left_reg == '0) || (bytes_left_reg == CW'(1));

    // block that a finished line announces
    always_comb
    begin
        blk_type = absd_pkg::MSG_LINE;
        blk_len  = '0;
        blk_skip = '0;
        if (prefix_ok)
        begin
            if (head_hit_reg[absd_pkg::HEAD_P] || head_hit_reg[absd_pkg::HEAD_T])
            begin
                blk_type = absd_pkg::MSG_SAMPLE;
                blk_len  = (under_cnt_reg == 2'd3) ? CW'(accum_reg) : '0;
            end
            else if (head_hit_reg[absd_pkg::HEAD_C])
            begin
                blk_type = absd_pkg::MSG_PARAMS;
                blk_len  = (under_cnt_reg == 2'd3) ? CW'(accum_reg) : '0;
            end
            else if (head_hit_reg[absd_pkg::HEAD_O])
            begin
                blk_type = absd_pkg::MSG_OP_STATUS;
                blk_len  = CW'(op_len_reg);
                blk_skip = pad_skip;
            end
            else if (head_hit_reg[absd_pkg::HEAD_S])
            begin
                blk_type = absd_pkg::MSG_SCOPE;
                blk_len  = CW'(scope_len_reg);
                blk_skip = pad_skip;
            end
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        line_len_next    = line_len_reg;
        under_cnt_next   = under_cnt_reg;
        accum_next       = accum_reg;
        digits_done_next = digits_done_reg;
        skip_left_next   = skip_left_reg;
        bytes_left_next  = bytes_left_reg;
        overflow_next    = overflow_reg;
        head_hit_next    = head_hit_reg;
        tail_ok_next     = tail_ok_reg;
        store_busy_next  = store_busy_reg;
        op_len_next      = op_len_reg;
        scope_len_next   = scope_len_reg;
        push             = 1'b0;
        push_cmd         = '0;
        wr_en            = 1'b0;
        wr_addr          = line_len_reg[absd_pkg::ADDR_W-1:0];
        wr_data          = ch;

        if (flush_done)
        begin
            store_busy_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            if (cfg_index == absd_pkg::CFG_OP_STATUS)
            begin
                op_len_next = cfg_wr_data;
            end
            else
            begin
                scope_len_next = cfg_wr_data;
            end
        end

        if (take)
        begin
            if (in_item.kind)
            begin
                // link lost: drop everything, report once
                push                    = 1'b1;
                push_cmd.item.msg_type  = absd_pkg::MSG_ERROR;
                push_cmd.item.last      = 1'b1;
                mode_next               = absd_pkg::MSG_LINE;
                line_len_next           = '0;
                under_cnt_next          = '0;
                accum_next              = '0;
                digits_done_next        = 1'b0;
                overflow_next           = 1'b0;
                skip_left_next          = '0;
                bytes_left_next         = '0;
            end
            else if (mode_reg != absd_pkg::MSG_LINE)
            begin
                if (skip_left_reg != '0)
                begin
                    skip_left_next = skip_left_reg - 1'b1;
                end
                else
                begin
                    push                    = 1'b1;
                    push_cmd.item.msg_type  = mode_reg;
                    push_cmd.item.data_byte = ch;
                    push_cmd.item.last      = fin;
                    if (fin)
                    begin
                        mode_next       = absd_pkg::MSG_LINE;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 1'b1;
                    end
                end
            end
            else if ((ch == absd_pkg::CH_LF) || ((line_len_reg == '0)
                     && ((ch == absd_pkg::CH_PLUS) || (ch == absd_pkg::CH_QUEST))))
            begin
                if (line_len_reg == '0)
                begin
                    if (ch == absd_pkg::CH_PLUS)
                    begin
                        push                    = 1'b1;
                        push_cmd.item.msg_type  = absd_pkg::MSG_LINE;
                        push_cmd.item.data_byte = absd_pkg::CH_PLUS;
                        push_cmd.item.last      = 1'b1;
                    end
                end
                else
                begin
                    push                    = 1'b1;
                    push_cmd.is_flush       = 1'b1;
                    push_cmd.count          = line_len_reg;
                    push_cmd.item.msg_type  = absd_pkg::MSG_LINE;
                    push_cmd.item.truncated = overflow_reg;
                    store_busy_next         = 1'b1;
                    if (blk_len != '0)
                    begin
                        mode_next       = blk_type;
                        bytes_left_next = blk_len;
                        skip_left_next  = blk_skip;
                    end
                end
                line_len_next    = '0;
                under_cnt_next   = '0;
                accum_next       = '0;
                digits_done_next = 1'b0;
                overflow_next    = 1'b0;
            end
            else if (ch != absd_pkg::CH_CR)
            begin
                if (line_len_reg < LW'(absd_pkg::LINE_MAX))
                begin
                    wr_en         = 1'b1;
                    line_len_next = line_len_reg + 1'b1;
                    // header tracking over the first seven characters
                    if (line_len_reg == '0)
                    begin
                        head_hit_next = {ch == absd_pkg::CH_S, ch == absd_pkg::CH_O,
                                         ch == absd_pkg::CH_C, ch == absd_pkg::CH_T,
                                         ch == absd_pkg::CH_P};
                        tail_ok_next  = 1'b1;
                    end
                    else if (line_len_reg < LW'(absd_pkg::PREFIX_LEN))
                    begin
                        tail_ok_next = tail_ok_reg
                                     && (ch == absd_pkg::tail_char(line_len_reg[2:0]));
                    end
                end
                else
                begin
                    overflow_next = 1'b1;
                end

                if (under_cnt_reg != 2'd3)
                begin
                    if (ch == absd_pkg::CH_UNDER)
                    begin
                        under_cnt_next = under_cnt_reg + 1'b1;
                    end
                end
                else if (!digits_done_reg)
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_sat;
                    end
                    else
                    begin
                        digits_done_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= absd_pkg::MSG_LINE;
            line_len_reg    <= '0;
            under_cnt_reg   <= '0;
            accum_reg       <= '0;
            digits_done_reg <= 1'b0;
            skip_left_reg   <= '0;
            bytes_left_reg  <= '0;
            overflow_reg    <= 1'b0;
            head_hit_reg    <= '0;
            tail_ok_reg     <= 1'b0;
            store_busy_reg  <= 1'b0;
            op_len_reg      <= absd_pkg::CFG_W'(absd_pkg::CFG_RESET);
            scope_len_reg   <= absd_pkg::CFG_W'(absd_pkg::CFG_RESET);
        end
        else
        begin
            mode_reg        <= mode_next;
            line_len_reg    <= line_len_next;
            under_cnt_reg   <= under_cnt_next;
            accum_reg       <= accum_next;
            digits_done_reg <= digits_done_next;
            skip_left_reg   <= skip_left_next;
            bytes_left_reg  <= bytes_left_next;
            overflow_reg    <= overflow_next;
            head_hit_reg    <= head_hit_next;
            tail_ok_reg     <= tail_ok_next;
            store_busy_reg  <= store_busy_next;
            op_len_reg      <= op_len_next;
            scope_len_reg   <= scope_len_next;
        end
    end

endmodule

### rtl/absd_back.sv
`timescale 1ns / 1ps

module absd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fifo_empty,
    input  absd_pkg::cmd_t                head,
    output logic                          pop,
    output logic                          rd_en,
    output logic [absd_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          flush_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output absd_pkg::out_item_t           out_item
);

    localparam int AW = absd_pkg::ADDR_W;
    localparam int LW = absd_pkg::LEN_W;

    absd_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    logic                  trunc_reg, trunc_next;
    logic                  out_valid_reg, out_valid_next;
    absd_pkg::out_item_t   out_reg, out_next;
    logic                  slot_free;
    logic                  last_char;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_char = ((LW'(idx_reg) + 1'b1) == cnt_reg);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        trunc_next     = trunc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        flush_done     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            absd_pkg::B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    if (head.is_flush)
                    begin
                        // start read-out of the stored line
                        pop        = 1'b1;
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        cnt_next   = head.count;
                        trunc_next = head.item.truncated;
                        state_next = absd_pkg::B_LOAD;
                    end
                    else if (slot_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_next       = head.item;
                    end
                end
            end
            absd_pkg::B_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.msg_type  = absd_pkg::MSG_LINE;
                    out_next.data_byte = rd_data;
                    out_next.last      = last_char;
                    out_next.truncated = trunc_reg;
                    if (last_char)
                    begin
                        flush_done = 1'b1;
                        state_next = absd_pkg::B_IDLE;
                    end
                    else
                    begin
                        // fetch the next character while this one goes out
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = absd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= absd_pkg::B_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

### rtl/absd_checker.sv
`timescale 1ns / 1ps
`include "ascii_binary_stream_deframer_defines.svh"

module absd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input absd_pkg::out_item_t out_item
);

    `ABSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `ABSD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "stalled result changed")
    `ABSD_ASSERT_SAME(a_err_form, out_valid && (out_item.msg_type == absd_pkg::MSG_ERROR), (out_item.data_byte == 8'h00) && out_item.last && !out_item.truncated, "bad link error result")
    `ABSD_ASSERT_SAME(a_blk_trunc, out_valid && (out_item.msg_type != absd_pkg::MSG_LINE), !out_item.truncated, "block result flagged truncated")

endmodule

bind ascii_binary_stream_deframer absd_checker u_absd_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import absd_pkg::*;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_LOST = 1'b1;
    localparam int   DIR_ROWS = 25;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   LONG_BLOCK = 100;
    localparam logic [LEN_BITS-1:0] LEN_CAP = '1;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       typed;
        out_item_t  res;
    } feed_t;

    localparam out_item_t NO_RES = '0;
    localparam out_item_t LOST_RES = '{MSG_ERROR, 8'h00, 1'b1, 1'b0};

    localparam feed_t DIR_TAB [DIR_ROWS] = '{
        '{KIND_LOST, 8'hFF,    1'b1, LOST_RES},
        '{KIND_BYTE, CH_PLUS,  1'b1, '{MSG_LINE, CH_PLUS, 1'b1, 1'b0}},
        '{KIND_BYTE, CH_QUEST, 1'b0, NO_RES},
        '{KIND_BYTE, CH_LF,    1'b0, NO_RES},
        '{KIND_BYTE, CH_CR,    1'b0, NO_RES},
        '{KIND_BYTE, "C",      1'b0, NO_RES},
        '{KIND_BYTE, "_",      1'b0, NO_RES},
        '{KIND_BYTE, "B",      1'b0, NO_RES},
        '{KIND_BYTE, "E",      1'b0, NO_RES},
        '{KIND_BYTE, "G",      1'b0, NO_RES},
        '{KIND_BYTE, "I",      1'b0, NO_RES},
        '{KIND_BYTE, "N",      1'b0, NO_RES},
        '{KIND_BYTE, "_",      1'b0, NO_RES},
        '{KIND_BYTE, "_",      1'b0, NO_RES},
        '{KIND_BYTE, "3",      1'b0, NO_RES},
        '{KIND_BYTE, CH_CR,    1'b0, NO_RES},
        '{KIND_BYTE, CH_LF,    1'b0, NO_RES},
        '{KIND_BYTE, 8'h00,    1'b1, '{MSG_PARAMS, 8'h00, 1'b0, 1'b0}},
        '{KIND_BYTE, 8'hFF,    1'b1, '{MSG_PARAMS, 8'hFF, 1'b0, 1'b0}},
        '{KIND_BYTE, CH_LF,    1'b1, '{MSG_PARAMS, CH_LF, 1'b1, 1'b0}},
        '{KIND_BYTE, "X",      1'b0, NO_RES},
        '{KIND_LOST, 8'h00,    1'b1, LOST_RES},
        '{KIND_BYTE, 8'h00,    1'b0, NO_RES},
        '{KIND_BYTE, 8'hFF,    1'b0, NO_RES},
        '{KIND_BYTE, CH_LF,    1'b0, NO_RES}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_item;

    // deframer state as modelled by the testbench
    logic [2:0]          fr_mode;
    logic [7:0]          fr_store [LINE_MAX];
    int                  fr_len;
    int                  fr_unders;
    logic [LEN_BITS-1:0] fr_num;
    bit                  fr_num_done;
    int                  fr_skip;
    logic [LEN_BITS-1:0] fr_left;
    bit                  fr_ovf;
    logic [CFG_W-1:0]    op_status_len;
    logic [CFG_W-1:0]    scope_len;

    out_item_t pending_results [$];
    feed_t     link_q [$];
    bit        in_flight;
    int        queued_items;
    bit        tx_idle;
    bit        rx_idle;
    int        hold_req;
    int        fail_count;

    ascii_binary_stream_deframer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_result(logic [2:0] t, logic [7:0] d, logic l, logic tr);
        out_item_t r;
        r.msg_type  = t;
        r.data_byte = d;
        r.last      = l;
        r.truncated = tr;
        pending_results.push_back(r);
    endfunction

    function automatic void drop_line();
        fr_len      = 0;
        fr_unders   = 0;
        fr_num      = '0;
        fr_num_done = 1'b0;
        fr_ovf      = 1'b0;
    endfunction

    function automatic void store_char(logic [7:0] c);
        longint v;
        if (fr_len < LINE_MAX)
        begin
            fr_store[fr_len] = c;
            fr_len++;
        end
        else
            fr_ovf = 1'b1;
        // length digits are parsed even past the end of the store
        if (fr_unders < 3)
        begin
            if (c == CH_UNDER)
                fr_unders++;
        end
        else if (!fr_num_done)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                v = longint'(fr_num) * 10 + longint'(c - CH_ZERO);
                fr_num = (v > longint'(LEN_CAP)) ? LEN_CAP : v[LEN_BITS-1:0];
            end
            else
                fr_num_done = 1'b1;
        end
    endfunction

    function automatic void end_line(logic [7:0] c);
        logic [55:0]         head;
        logic [2:0]          blk;
        logic [LEN_BITS-1:0] blen;
        int                  pad;
        blk  = MSG_LINE;
        blen = '0;
        pad  = 0;
        if (fr_len == 0)
        begin
            if (c == CH_PLUS)
                push_result(MSG_LINE, CH_PLUS, 1'b1, 1'b0);
            drop_line();
            return;
        end
        for (int i = 0; i < fr_len; i++)
            push_result(MSG_LINE, fr_store[i], i == fr_len - 1, fr_ovf);
        if (fr_len >= PREFIX_LEN)
        begin
            head = {fr_store[0], fr_store[1], fr_store[2], fr_store[3],
                    fr_store[4], fr_store[5], fr_store[6]};
            case (head)
                "P_BEGIN", "T_BEGIN":
                begin
                    blk  = MSG_SAMPLE;
                    blen = (fr_unders == 3) ? fr_num : '0;
                end
                "C_BEGIN":
                begin
                    blk  = MSG_PARAMS;
                    blen = (fr_unders == 3) ? fr_num : '0;
                end
                "O_BEGIN":
                begin
                    blk  = MSG_OP_STATUS;
                    blen = LEN_BITS'(op_status_len);
                    pad  = PAD_END - fr_len;
                end
                "S_BEGIN":
                begin
                    blk  = MSG_SCOPE;
                    blen = LEN_BITS'(scope_len);
                    pad  = PAD_END - fr_len;
                end
                default:
                    blk = MSG_LINE;
            endcase
        end
        if (blk != MSG_LINE && blen != 0)
        begin
            fr_mode = blk;
            fr_left = blen;
            fr_skip = (pad > 0) ? pad : 0;
        end
        drop_line();
    endfunction

    function automatic void deframe(in_item_t it);
        logic [7:0] b;
        b = it.byte_value;
        if (it.kind == KIND_LOST)
        begin
            fr_mode = MSG_LINE;
            drop_line();
            fr_skip = 0;
            fr_left = '0;
            push_result(MSG_ERROR, 8'h00, 1'b1, 1'b0);
            return;
        end
        if (fr_mode != MSG_LINE)
        begin
            if (fr_skip > 0)
            begin
                fr_skip--;
                return;
            end
            push_result(fr_mode, b, fr_left <= 1, 1'b0);
            if (fr_left <= 1)
            begin
                fr_mode = MSG_LINE;
                fr_left = '0;
            end
            else
                fr_left--;
            return;
        end
        if (b == CH_LF || (fr_len == 0 && !fr_ovf && (b == CH_PLUS || b == CH_QUEST)))
            end_line(b);
        else if (b != CH_CR)
            store_char(b);
    endfunction

    // called at the edge where the input transfer happens
    function automatic void accept(feed_t f);
        int       mark;
        in_item_t it;
        it.kind       = f.kind;
        it.byte_value = f.byte_value;
        mark = pending_results.size();
        deframe(it);
        if (f.typed)
        begin
            while (pending_results.size() > mark)
                void'(pending_results.pop_back());
            pending_results.push_back(f.res);
        end
    endfunction

    function automatic void push_feed(logic k, logic [7:0] b);
        feed_t f;
        f.kind       = k;
        f.byte_value = b;
        f.typed      = 1'b0;
        f.res        = NO_RES;
        link_q.push_back(f);
        queued_items++;
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            push_feed(KIND_BYTE, s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // block payload; long or cut blocks end early with a link loss
    function automatic void push_block(int n, bit cut);
        int cnt;
        cnt = n;
        if (cut || n > LONG_BLOCK)
            cnt = $urandom_range(0, (n > 8) ? 8 : n - 1);
        repeat (cnt) push_feed(KIND_BYTE, 8'($urandom));
        if (cnt < n)
            push_feed(KIND_LOST, 8'($urandom));
    endfunction

    function automatic void text_line(int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom);
            if (c == CH_LF)
                c = CH_CR;
            push_feed(KIND_BYTE, c);
        end
        push_feed(KIND_BYTE, CH_LF);
    endfunction

    function automatic void length_frame(bit cut);
        string hdr;
        int    n;
        case ($urandom_range(0, 2))
            0:       hdr = "P_BEGIN";
            1:       hdr = "T_BEGIN";
            default: hdr = "C_BEGIN";
        endcase
        n = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0: push_str(hdr.substr(0, $urandom_range(0, 5)));   // prefix too short
            1: push_str({hdr, "_", $sformatf("%0d", n)});       // only two underscores
            2: push_str({hdr, "_Q_x"});                          // no digits
            3: push_str({hdr, "__00"});                          // zero length
            default:
            begin
                push_str(hdr);
                push_feed(KIND_BYTE, CH_UNDER);
                repeat ($urandom_range(0, 3)) push_feed(KIND_BYTE, rand_letter());
                push_feed(KIND_BYTE, CH_UNDER);
                push_str($sformatf("%0d", n));
                if ($urandom_range(0, 1))
                    push_str("_9x");
                if ($urandom_range(0, 1))
                    push_feed(KIND_BYTE, CH_CR);
                push_feed(KIND_BYTE, CH_LF);
                push_block(n, cut);
                return;
            end
        endcase
        push_feed(KIND_BYTE, CH_LF);
    endfunction

    function automatic void skip_frame(bit is_op, int extra, bit cut);
        int stored;
        push_str(is_op ? "O_BEGIN" : "S_BEGIN");
        repeat (extra) push_feed(KIND_BYTE, rand_letter());
        push_feed(KIND_BYTE, CH_LF);
        stored = (PREFIX_LEN + extra > LINE_MAX) ? LINE_MAX : PREFIX_LEN + extra;
        if (PAD_END > stored)
            repeat (PAD_END - stored) push_feed(KIND_BYTE, 8'($urandom));
        push_block(is_op ? int'(op_status_len) : int'(scope_len), cut);
    endfunction

    function automatic void random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            text_line($urandom_range(0, 12));
        else if (r < 30)
        begin
            case ($urandom_range(0, 3))
                0:       push_feed(KIND_BYTE, CH_PLUS);
                1:       push_feed(KIND_BYTE, CH_QUEST);
                2:       push_feed(KIND_BYTE, CH_LF);
                default:
                begin
                    push_feed(KIND_BYTE, CH_CR);
                    push_feed(KIND_BYTE, CH_LF);
                end
            endcase
        end
        else if (r < 50)
            length_frame(1'b0);
        else if (r < 65)
            skip_frame(1'($urandom_range(0, 1)), $urandom_range(0, 5), 1'b0);
        else if (r < 75)
        begin
            if ($urandom_range(0, 1))
                length_frame(1'b1);
            else
                skip_frame(1'($urandom_range(0, 1)), $urandom_range(0, 5), 1'b1);
        end
        else if (r < 87)
        begin
            repeat ($urandom_range(1, 6))
                push_feed(($urandom_range(0, 7) == 0) ? KIND_LOST : KIND_BYTE, 8'($urandom));
        end
        else if (r < 95)
        begin
            // partial line thrown away by a link loss
            repeat ($urandom_range(1, 8)) push_feed(KIND_BYTE, rand_letter());
            push_feed(KIND_LOST, 8'($urandom));
        end
        else if (r < 97)
            text_line($urandom_range(60, 72));
        else
            push_feed(KIND_LOST, 8'($urandom));
    endfunction

    function automatic void run_random(int n);
        int target;
        target = queued_items + n;
        while (queued_items < target)
            random_frame();
    endfunction

    task automatic settle();
        while (link_q.size() != 0 || in_flight || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_OP_STATUS)
            op_status_len = val;
        else
            scope_len = val;
    endtask

    function automatic void field_error(string name, logic [7:0] want, logic [7:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    endfunction

    initial
    begin : feeder
        feed_t f;
        int    gap;
        in_valid  <= 1'b0;
        in_item   <= '0;
        in_flight = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (link_q.size() == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                f = link_q.pop_front();
                in_flight = 1'b1;
                gap = tx_idle ? $urandom_range(0, 3) : 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                in_item  <= in_item_t'{f.kind, f.byte_value};
                in_valid <= 1'b1;
                do @(posedge clk); while (!in_ready);
                accept(f);
                in_flight = 1'b0;
            end
        end
    end

    initial
    begin : sink
        int quiet;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // a requested long hold-off is folded into the next wait
            quiet = hold_req + (rx_idle ? $urandom_range(0, 3) : 0);
            hold_req = 0;
            if (quiet > 0)
            begin
                out_ready <= 1'b0;
                repeat (quiet) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected transfer, expected none, actual %p", $time,
                         out_item);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.msg_type !== want.msg_type)
                    field_error("msg_type", 8'(want.msg_type), 8'(out_item.msg_type));
                if (out_item.data_byte !== want.data_byte)
                    field_error("data_byte", want.data_byte, out_item.data_byte);
                if (out_item.last !== want.last)
                    field_error("last", 8'(want.last), 8'(out_item.last));
                if (out_item.truncated !== want.truncated)
                    field_error("truncated", 8'(want.truncated), 8'(out_item.truncated));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : run
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_OP_STATUS;
        cfg_wr_data <= '0;
        rst_n = 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_req = 0;
        fail_count = 0;
        queued_items = 0;
        fr_mode = MSG_LINE;
        drop_line();
        fr_skip = 0;
        fr_left = '0;
        op_status_len = CFG_W'(CFG_RESET);
        scope_len = CFG_W'(CFG_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            link_q.push_back(DIR_TAB[i]);
            queued_items++;
        end
        settle();

        // longest scope block, single-byte op status block
        write_reg(CFG_OP_STATUS, 16'd1);
        write_reg(CFG_SCOPE, 16'hFFFF);
        skip_frame(1'b0, 0, 1'b0);
        skip_frame(1'b1, 2, 1'b0);
        run_random(20);
        settle();

        // back to back, with the receiver held off long enough to fill the queue
        write_reg(CFG_OP_STATUS, 16'hFFFF);
        write_reg(CFG_SCOPE, 16'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_req = 300;
        push_str("P_BEGIN__99999999");
        push_feed(KIND_BYTE, CH_LF);
        push_block(int'(LEN_CAP), 1'b0);
        skip_frame(1'b1, 3, 1'b0);
        run_random(20);
        settle();

        // small lengths, overflowed header lines
        write_reg(CFG_OP_STATUS, 16'($urandom_range(2, 9)));
        write_reg(CFG_SCOPE, 16'($urandom_range(2, 9)));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        push_str("P_BEGIN");
        repeat (58) push_feed(KIND_BYTE, rand_letter());
        push_str("__5");
        push_feed(KIND_BYTE, CH_LF);
        push_block(5, 1'b0);
        skip_frame(1'b1, 60, 1'b0);
        run_random(10);
        settle();
        run_random(10);
        settle();

        write_reg(CFG_OP_STATUS, 16'(CFG_RESET));
        write_reg(CFG_SCOPE, 16'd3);
        rx_idle = 1'b0;
        skip_frame(1'b1, 1, 1'b0);
        run_random(20);
        settle();

        if (fail_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
